// ===== hw/rtl/nwf_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table of the next-waypoint finder.
// Depends on nothing; every other file of the block imports it.
package nwf_pkg;

   // Default values of the top-level parameters.
   localparam int MAP_DEPTH_DEFAULT   = 1024;
   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int ANGLE_WIDTH_DEFAULT = 16;

   // Fixed widths of the interface fields.
   localparam int INDEX_W   = 10;
   localparam int COUNT_W   = 11;
   localparam int COORD_W   = 32;
   localparam int HEADING_W = 16;
   localparam int DIFF_W    = 16;

   // Distance sentinel: 100000 m in Q23.8, and its square in Q.16.
   localparam int SENT_W = 25;
   localparam int D2_W   = 2 * SENT_W + 1;
   localparam logic [SENT_W-1:0] SENTINEL    = 25'd25600000;
   localparam logic [D2_W-1:0]   SENTINEL_SQ = 51'd655360000000000;

   // Command codes of an input item.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic                       command;
      logic [INDEX_W-1:0]         waypoint_index;
      logic signed [COORD_W-1:0]  waypoint_x;
      logic signed [COORD_W-1:0]  waypoint_y;
      logic signed [COORD_W-1:0]  vehicle_x;
      logic signed [COORD_W-1:0]  vehicle_y;
      logic [HEADING_W-1:0]       vehicle_heading;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] closest_index;
      logic [INDEX_W-1:0] next_index;
      logic [DIFF_W-1:0]  bearing_difference;
      logic               map_empty;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FETCH,
      ST_LOAD,
      ST_ROTATE,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept_write;
      logic accept_query;
      logic scan_issue;
      logic fetch;
      logic load;
      logic rotate;
      logic finish;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic map_empty;
      logic scan_last;
      logic pipe_busy;
      logic cordic_done;
      logic rsp_free;
   } dp_status_type;

   // Arctangent of 2^-i as a fraction of a turn with 32 fractional bits.
   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] a;
      case (i)
         5'd0:    a = 32'h20000000;
         5'd1:    a = 32'h12E4051E;
         5'd2:    a = 32'h09FB385B;
         5'd3:    a = 32'h051111D4;
         5'd4:    a = 32'h028B0D43;
         5'd5:    a = 32'h0145D7E1;
         5'd6:    a = 32'h00A2F61E;
         5'd7:    a = 32'h00517C55;
         5'd8:    a = 32'h0028BE53;
         5'd9:    a = 32'h00145F2F;
         5'd10:   a = 32'h000A2F98;
         5'd11:   a = 32'h000517CC;
         5'd12:   a = 32'h00028BE6;
         5'd13:   a = 32'h000145F3;
         5'd14:   a = 32'h0000A2FA;
         5'd15:   a = 32'h0000517D;
         5'd16:   a = 32'h000028BE;
         5'd17:   a = 32'h0000145F;
         5'd18:   a = 32'h00000A30;
         5'd19:   a = 32'h00000518;
         5'd20:   a = 32'h0000028C;
         5'd21:   a = 32'h00000146;
         5'd22:   a = 32'h000000A3;
         5'd23:   a = 32'h00000051;
         5'd24:   a = 32'h00000029;
         5'd25:   a = 32'h00000014;
         5'd26:   a = 32'h0000000A;
         5'd27:   a = 32'h00000005;
         5'd28:   a = 32'h00000003;
         5'd29:   a = 32'h00000001;
         5'd30:   a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

// ===== hw/rtl/next_waypoint_finder_top.sv =====
// Top level of the next-waypoint finder: joins the controller and the datapath.
// Depends on nwf_pkg, nwf_ctrl and nwf_datapath.
//
// Usage. The req channel carries items of two kinds. A write item (command 0)
// stores one waypoint in the table and is done in the cycle it is accepted; it
// returns nothing. A query item (command 1) returns exactly one item on the rsp
// channel: the nearest waypoint among the first waypoint_count entries, the
// index to steer for next, the folded heading error and an empty-map flag.
// The csr port writes waypoint_count. The user must write it only while no
// query runs; the block itself does not enforce this. A query works in
// order: the distance scan reads one entry per cycle from the single memory
// read port, the distance pipeline drains, the closest entry is fetched and
// loaded, and the CORDIC unit does ANGLE_WIDTH + 4 steps (at most 32), one
// per cycle. An empty-map query skips these steps and goes straight to the
// result. req_ready rises in the same cycle as the result appears. One item
// is worked on at a time.
// Reset clears the controller, the pipeline valid bits, the result valid bit
// and waypoint_count; the table itself is not cleared and must be written
// before it is searched. When the receiver stalls, the finished result waits
// in the output register, and a further item is still taken; a query that
// finishes behind a stalled result holds until that result is taken.
module next_waypoint_finder_top #(
   parameter int MAP_DEPTH   = nwf_pkg::MAP_DEPTH_DEFAULT,
   parameter int COORD_WIDTH = nwf_pkg::COORD_WIDTH_DEFAULT,
   parameter int ANGLE_WIDTH = nwf_pkg::ANGLE_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  nwf_pkg::req_type            req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output nwf_pkg::rsp_type            rsp_payload,
   input  logic                        csr_write_enable,
   input  logic [nwf_pkg::COUNT_W-1:0] csr_write_data
);
   import nwf_pkg::*;

   // Command and status groups between the two halves.
   ctrl_cmd_type  cmd;
   dp_status_type status;

   // The controller sequences a query: scan, drain, fetch, CORDIC, result.
   nwf_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_payload.command),
      .status      (status),
      .req_ready   (req_ready),
      .cmd         (cmd)
   );

   // The datapath holds the table, the distance pipeline and the CORDIC unit.
   nwf_datapath #(
      .MAP_DEPTH   (MAP_DEPTH),
      .COORD_WIDTH (COORD_WIDTH),
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_payload      (req_payload),
      .cmd              (cmd),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_payload      (rsp_payload),
      .status           (status)
   );

endmodule

// ===== hw/rtl/nwf_ctrl.sv =====
// Controller state machine of the next-waypoint finder.
// Depends on nwf_pkg; drives the datapath through ctrl_cmd_type commands.
module nwf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_command,
   input  nwf_pkg::dp_status_type status,
   output logic                   req_ready,
   output nwf_pkg::ctrl_cmd_type  cmd
);
   import nwf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == CMD_QUERY) begin
                  cmd.accept_query = 1'b1;
                  state_in = status.map_empty ? ST_FINISH : ST_SCAN;
               end else begin
                  cmd.accept_write = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (status.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.load = 1'b1;
            state_in = ST_ROTATE;
         end
         ST_ROTATE: begin
            cmd.rotate = 1'b1;
            if (status.cordic_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/nwf_datapath.sv =====
// Datapath of the next-waypoint finder: waypoint memory, distance pipeline,
// CORDIC bearing unit and result register. Depends on nwf_pkg.
module nwf_datapath #(
   parameter int MAP_DEPTH   = nwf_pkg::MAP_DEPTH_DEFAULT,
   parameter int COORD_WIDTH = nwf_pkg::COORD_WIDTH_DEFAULT,
   parameter int ANGLE_WIDTH = nwf_pkg::ANGLE_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  nwf_pkg::req_type             req_payload,
   input  nwf_pkg::ctrl_cmd_type        cmd,
   input  logic                         csr_write_enable,
   input  logic [nwf_pkg::COUNT_W-1:0]  csr_write_data,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output nwf_pkg::rsp_type             rsp_payload,
   output nwf_pkg::dp_status_type       status
);
   import nwf_pkg::*;

   localparam int IDX_W  = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int CNT_W  = $clog2(MAP_DEPTH + 1);
   localparam int DW     = COORD_WIDTH + 1;
   localparam int SQW    = (DW < SENT_W) ? DW : SENT_W;
   localparam int CW     = COORD_WIDTH + 4;
   localparam int STEPS  = (ANGLE_WIDTH + 4 < 32) ? ANGLE_WIDTH + 4 : 32;
   localparam int ITER_W = $clog2(STEPS);
   localparam logic [ANGLE_WIDTH-1:0] HALF    = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 1);
   localparam logic [ANGLE_WIDTH-1:0] QUARTER = ANGLE_WIDTH'(1) << (ANGLE_WIDTH - 2);
   localparam logic [32:0]            ROUND   = 33'(1) << (31 - ANGLE_WIDTH);

   // Configuration and count in use.
   logic [COUNT_W-1:0] count_ff;
   logic [31:0]        count_wide;
   logic [CNT_W-1:0]   cnt_use;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   assign count_wide = 32'(count_ff);
   assign cnt_use    = CNT_W'((count_wide > 32'(MAP_DEPTH)) ? 32'(MAP_DEPTH) : count_wide);

   // Waypoint memory, y in the upper half of each word.
   logic [2*COORD_WIDTH-1:0] mem [MAP_DEPTH];
   logic [2*COORD_WIDTH-1:0] rd_data_ff;
   logic                     wr_in_range;
   logic [IDX_W-1:0]         wr_addr, rd_addr;
   logic                     rd_en;
   logic [IDX_W-1:0]         addr_ff;
   logic [IDX_W-1:0]         closest_ff;

   assign wr_in_range = 32'(req_payload.waypoint_index) < 32'(MAP_DEPTH);
   assign wr_addr     = IDX_W'(req_payload.waypoint_index);
   assign rd_en       = cmd.scan_issue | cmd.fetch;
   assign rd_addr     = cmd.fetch ? closest_ff : addr_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept_write && wr_in_range) begin
         mem[wr_addr] <= {req_payload.waypoint_y[COORD_WIDTH-1:0],
                          req_payload.waypoint_x[COORD_WIDTH-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Query operands.
   logic signed [COORD_WIDTH-1:0] vx_ff, vy_ff;
   logic [ANGLE_WIDTH-1:0]        heading_ff;
   logic [31:0]                   heading_wide;
   logic                          empty_ff;

   assign heading_wide = 32'(req_payload.vehicle_heading);

   always_ff @(posedge clock) begin
      if (cmd.accept_query) begin
         vx_ff      <= req_payload.vehicle_x[COORD_WIDTH-1:0];
         vy_ff      <= req_payload.vehicle_y[COORD_WIDTH-1:0];
         heading_ff <= heading_wide[ANGLE_WIDTH-1:0];
         empty_ff   <= (cnt_use == '0);
      end
   end

   // Scan address counter.
   always_ff @(posedge clock) begin
      if (cmd.accept_query) begin
         addr_ff <= '0;
      end else if (cmd.scan_issue) begin
         addr_ff <= addr_ff + IDX_W'(1);
      end
   end

   // Distance pipeline: read, offset and range check, squares, sum and compare.
   logic signed [COORD_WIDTH-1:0] rd_x, rd_y;
   logic signed [DW-1:0]          dx, dy;
   logic [DW-1:0]                 mag_x, mag_y;
   logic                          far;
   logic                          p0_valid_ff, p1_valid_ff, p2_valid_ff;
   logic [IDX_W-1:0]              p0_idx_ff, p1_idx_ff, p2_idx_ff;
   logic [SQW-1:0]                p1_mx_ff, p1_my_ff;
   logic [2*SQW-1:0]              p2_sqx_ff, p2_sqy_ff;
   logic [D2_W-1:0]               d2_sum;
   logic [D2_W-1:0]               best_ff;

   assign rd_x  = rd_data_ff[COORD_WIDTH-1:0];
   assign rd_y  = rd_data_ff[2*COORD_WIDTH-1:COORD_WIDTH];
   assign dx    = DW'(rd_x) - DW'(vx_ff);
   assign dy    = DW'(rd_y) - DW'(vy_ff);
   assign mag_x = dx[DW-1] ? DW'(-dx) : DW'(dx);
   assign mag_y = dy[DW-1] ? DW'(-dy) : DW'(dy);
   assign far   = (64'(mag_x) >= 64'(SENTINEL)) || (64'(mag_y) >= 64'(SENTINEL));
   assign d2_sum = D2_W'(p2_sqx_ff) + D2_W'(p2_sqy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p0_valid_ff <= cmd.scan_issue;
         p1_valid_ff <= p0_valid_ff && !far;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p0_idx_ff <= addr_ff;
      p1_idx_ff <= p0_idx_ff;
      p1_mx_ff  <= mag_x[SQW-1:0];
      p1_my_ff  <= mag_y[SQW-1:0];
      p2_idx_ff <= p1_idx_ff;
      p2_sqx_ff <= p1_mx_ff * p1_mx_ff;
      p2_sqy_ff <= p1_my_ff * p1_my_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_query) begin
         best_ff    <= SENTINEL_SQ;
         closest_ff <= '0;
      end else if (p2_valid_ff && (d2_sum < best_ff)) begin
         best_ff    <= d2_sum;
         closest_ff <= p2_idx_ff;
      end
   end

   // CORDIC vectoring unit, one step per cycle.
   logic signed [CW-1:0] ddx, ddy;
   logic signed [CW-1:0] cx_ff, cy_ff;
   logic signed [CW-1:0] xs, ys;
   logic [31:0]          cz_ff;
   logic [31:0]          atan_val;
   logic [ITER_W-1:0]    iter_ff;
   logic                 zero_ff;

   assign ddx      = CW'(rd_x) - CW'(vx_ff);
   assign ddy      = CW'(rd_y) - CW'(vy_ff);
   assign xs       = cx_ff >>> iter_ff;
   assign ys       = cy_ff >>> iter_ff;
   assign atan_val = atan_turn(5'(iter_ff));

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         zero_ff <= (ddx == '0) && (ddy == '0);
         iter_ff <= '0;
         if (ddx < 0) begin
            cx_ff <= -ddx;
            cy_ff <= -ddy;
            cz_ff <= 32'h80000000;
         end else begin
            cx_ff <= ddx;
            cy_ff <= ddy;
            cz_ff <= 32'h00000000;
         end
      end else if (cmd.rotate) begin
         iter_ff <= iter_ff + ITER_W'(1);
         if (cy_ff > 0) begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + atan_val;
         end else begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - atan_val;
         end
      end
   end

   // Bearing, folded difference and next index.
   logic [32:0]            z_round;
   logic [ANGLE_WIDTH-1:0] bearing, diff_raw, diff_fold;
   logic [CNT_W-1:0]       closest_plus;
   logic [IDX_W-1:0]       wrapped, next_idx;

   assign z_round      = {1'b0, cz_ff} + ROUND;
   assign bearing      = zero_ff ? '0 : z_round[31 -: ANGLE_WIDTH];
   assign diff_raw     = heading_ff - bearing;
   assign diff_fold    = (diff_raw > HALF) ? ANGLE_WIDTH'(-diff_raw) : diff_raw;
   assign closest_plus = CNT_W'(closest_ff) + CNT_W'(1);
   assign wrapped      = (closest_plus == cnt_use) ? '0 : IDX_W'(closest_plus);
   assign next_idx     = (diff_fold > QUARTER) ? wrapped : closest_ff;

   // Result register.
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (empty_ff) begin
            rsp_ff.closest_index      <= '0;
            rsp_ff.next_index         <= '0;
            rsp_ff.bearing_difference <= '0;
            rsp_ff.map_empty          <= 1'b1;
         end else begin
            rsp_ff.closest_index      <= INDEX_W'(closest_ff);
            rsp_ff.next_index         <= INDEX_W'(next_idx);
            rsp_ff.bearing_difference <= DIFF_W'(diff_fold);
            rsp_ff.map_empty          <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign status.map_empty   = (cnt_use == '0);
   assign status.scan_last   = (CNT_W'(addr_ff) == cnt_use - CNT_W'(1));
   assign status.pipe_busy   = p0_valid_ff | p1_valid_ff | p2_valid_ff;
   assign status.cordic_done = (iter_ff == ITER_W'(STEPS - 1));
   assign status.rsp_free    = !rsp_valid_ff || rsp_ready;

endmodule
